>>> design/dmfs_pkg.sv
// Package for the delimiter mask field splitter: record and job types,
// character codes, status codes, sizes and small helper functions.
// No dependencies.
package dmfs_pkg;

    localparam int MAX_FIELDS  = 6;
    localparam int MASK_BYTES  = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_CR   = 8'h0d;
    localparam logic [7:0] CHAR_LF   = 8'h0a;

    // register indexes on the configuration port
    localparam logic REG_DELIM_COUNT = 1'b0;
    localparam logic REG_DELIM_CHARS = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_COMMENT    = 2'd2,
        ST_EMPTY      = 2'd3
    } line_status_t;

    typedef enum logic {
        KIND_FIELD  = 1'b0,
        KIND_STATUS = 1'b1
    } record_kind_t;

    typedef struct packed {
        record_kind_t kind;
        logic [2:0]   index;
        logic [7:0]   start;
        logic [7:0]   length;
        line_status_t status;
    } rec_t;

    // one or two records produced by one input byte
    typedef struct packed {
        logic two;
        rec_t rec1;
        rec_t rec0;
    } job_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hff) ? 8'hff : v + 8'd1;
    endfunction

endpackage

>>> design/delimiter_mask_field_splitter.sv
// Top level of the delimiter mask field splitter: front end, job queue
// and back end. Depends on dmfs_pkg, dmfs_front, dmfs_queue, dmfs_back.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_data_byte, s_buffer_last
//   m_        out        m_valid/m_ready    record fields, m_last
//   cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// One input byte per cycle is taken while the queue has room; a byte is
// classified and the line state updated in the cycle of its transaction.
// Each byte yields zero, one or two records; the back end sends one record
// per cycle while m_ready is high, so a byte that ends a line with an open
// field yields two. The four-entry queue absorbs that and lets either side stall.
// aresetn is synchronous; it empties the queue and the output register,
// restores the line state and sets delimiter_count to 1, the mask to zero.
module delimiter_mask_field_splitter (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wdata,
    // input bytes
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_buffer_last,
    // records
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_record_kind,
    output logic [2:0]  m_field_index,
    output logic [7:0]  m_field_start,
    output logic [7:0]  m_field_length,
    output logic [1:0]  m_line_status,
    output logic        m_last
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            q_empty;
    logic            q_full;
    dmfs_pkg::job_t  front_job;
    dmfs_pkg::job_t  head_job;
    dmfs_pkg::rec_t  out_rec;

    // ready depends only on queue room, never on the output side directly
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    dmfs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .data_byte   (s_data_byte),
        .buffer_last (s_buffer_last),
        .push        (push),
        .job         (front_job)
    );

    dmfs_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (front_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    dmfs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_rec    (out_rec),
        .m_last   (m_last)
    );

    assign m_record_kind  = out_rec.kind;
    assign m_field_index  = out_rec.index;
    assign m_field_start  = out_rec.start;
    assign m_field_length = out_rec.length;
    assign m_line_status  = out_rec.status;

endmodule

>>> design/dmfs_front.sv
// Front end: holds the configuration registers and the per-line state,
// classifies each accepted byte and builds the job of records it causes.
// Depends on dmfs_pkg.
module dmfs_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [63:0]     cfg_wdata,
    input  logic            accept,
    input  logic [7:0]      data_byte,
    input  logic            buffer_last,
    output logic            push,
    output dmfs_pkg::job_t  job
);

    logic [3:0]             delim_count_reg;
    logic [63:0]            delim_chars_reg;

    logic [7:0]             line_pos_reg,   line_pos_next;
    logic [3:0]             mask_pos_reg,   mask_pos_next;
    logic [2:0]             field_num_reg,  field_num_next;
    logic [7:0]             field_begin_reg, field_begin_next;
    logic [7:0]             field_cnt_reg,  field_cnt_next;
    dmfs_pkg::line_status_t line_res_reg,   line_res_next;
    logic                   skip_reg,       skip_next;

    logic [3:0] cnt_eff;
    logic [7:0] mask_char;
    logic [3:0] mask_pos_inc;
    logic [7:0] cnt_inc;
    logic       is_hash, is_lf, is_cr, is_other, match, line_end;
    logic       have_field;
    dmfs_pkg::rec_t fld_rec, st_rec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_count_reg <= 4'd1;
            delim_chars_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                dmfs_pkg::REG_DELIM_COUNT: delim_count_reg <= cfg_wdata[3:0];
                default:                   delim_chars_reg <= cfg_wdata;
            endcase
        end
    end

    always_comb begin
        if (delim_count_reg == 4'd0)
            cnt_eff = 4'd1;
        else if (delim_count_reg > 4'(dmfs_pkg::MASK_BYTES))
            cnt_eff = 4'(dmfs_pkg::MASK_BYTES);
        else
            cnt_eff = delim_count_reg;
    end

    assign mask_char    = delim_chars_reg[{mask_pos_reg[2:0], 3'b000} +: 8];
    assign mask_pos_inc = mask_pos_reg + 4'd1;
    assign cnt_inc      = dmfs_pkg::sat_inc(field_cnt_reg);

    assign is_hash  = data_byte == dmfs_pkg::CHAR_HASH;
    assign is_lf    = data_byte == dmfs_pkg::CHAR_LF;
    assign is_cr    = data_byte == dmfs_pkg::CHAR_CR;
    assign is_other = !skip_reg && !is_hash && !is_lf && !is_cr;
    assign match    = is_other && (data_byte == mask_char);
    assign line_end = buffer_last || is_lf;

    // an open or just-closed field is reported on this byte
    assign have_field = !skip_reg &&
                        (is_lf || (is_cr && buffer_last) || match ||
                         (is_other && !match && buffer_last));

    always_comb begin
        line_pos_next    = dmfs_pkg::sat_inc(line_pos_reg);
        mask_pos_next    = mask_pos_reg;
        field_num_next   = field_num_reg;
        field_begin_next = field_begin_reg;
        field_cnt_next   = field_cnt_reg;
        line_res_next    = line_res_reg;
        skip_next        = skip_reg;
        if (!skip_reg) begin
            if (is_hash) begin
                line_res_next = dmfs_pkg::ST_COMMENT;
                skip_next     = 1'b1;
            end else if (match) begin
                line_res_next  = dmfs_pkg::ST_INCOMPLETE;
                field_cnt_next = '0;
                mask_pos_next  = mask_pos_inc;
                if (mask_pos_inc >= cnt_eff) begin
                    line_res_next = dmfs_pkg::ST_OK;
                    skip_next     = 1'b1;
                end else if ({1'b0, field_num_reg} + 4'd1 >= 4'(dmfs_pkg::MAX_FIELDS)) begin
                    skip_next = 1'b1;
                end else begin
                    field_num_next   = field_num_reg + 3'd1;
                    field_begin_next = dmfs_pkg::sat_inc(line_pos_reg);
                end
            end else if (is_other) begin
                field_cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && line_end)) begin
            line_pos_reg    <= '0;
            mask_pos_reg    <= '0;
            field_num_reg   <= '0;
            field_begin_reg <= '0;
            field_cnt_reg   <= '0;
            line_res_reg    <= dmfs_pkg::ST_EMPTY;
            skip_reg        <= 1'b0;
        end else if (accept) begin
            line_pos_reg    <= line_pos_next;
            mask_pos_reg    <= mask_pos_next;
            field_num_reg   <= field_num_next;
            field_begin_reg <= field_begin_next;
            field_cnt_reg   <= field_cnt_next;
            line_res_reg    <= line_res_next;
            skip_reg        <= skip_next;
        end
    end

    always_comb begin
        fld_rec.kind   = dmfs_pkg::KIND_FIELD;
        fld_rec.index  = field_num_reg;
        fld_rec.start  = field_begin_reg;
        fld_rec.length = (is_other && !match) ? cnt_inc : field_cnt_reg;
        fld_rec.status = dmfs_pkg::ST_OK;

        st_rec.kind    = dmfs_pkg::KIND_STATUS;
        st_rec.index   = '0;
        st_rec.start   = '0;
        st_rec.length  = '0;
        st_rec.status  = line_res_next;

        job.rec0 = have_field ? fld_rec : st_rec;
        job.rec1 = st_rec;
        job.two  = have_field && line_end;
    end

    assign push = accept && (have_field || line_end);

endmodule

>>> design/dmfs_queue.sv
// Short job queue between front end and back end.
// Depends on dmfs_pkg.
module dmfs_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  dmfs_pkg::job_t  push_job,
    input  logic            pop,
    output dmfs_pkg::job_t  head_job,
    output logic            empty,
    output logic            full
);

    dmfs_pkg::job_t                 mem [dmfs_pkg::QUEUE_DEPTH];
    logic [dmfs_pkg::QUEUE_AW-1:0]  wr_ptr_reg;
    logic [dmfs_pkg::QUEUE_AW-1:0]  rd_ptr_reg;
    logic [dmfs_pkg::QUEUE_CW-1:0]  count_reg, count_next;

    assign empty    = count_reg == '0;
    assign full     = count_reg == dmfs_pkg::QUEUE_CW'(dmfs_pkg::QUEUE_DEPTH);
    assign head_job = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

>>> design/dmfs_back.sv
// Back end: takes jobs from the queue and sends their records one per
// transaction from an output register. Depends on dmfs_pkg.
module dmfs_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  dmfs_pkg::job_t  head_job,
    input  logic            q_empty,
    output logic            pop,
    input  logic            m_ready,
    output logic            m_valid,
    output dmfs_pkg::rec_t  m_rec,
    output logic            m_last
);

    logic           valid_reg;
    dmfs_pkg::job_t job_reg;
    logic           sel_reg;
    logic           sel_is_last;

    assign sel_is_last = sel_reg == job_reg.two;
    assign pop         = !q_empty && (!valid_reg || (m_ready && sel_is_last));
    assign m_valid     = valid_reg;
    assign m_rec       = sel_reg ? job_reg.rec1 : job_reg.rec0;
    assign m_last      = sel_is_last;

    always_ff @(posedge aclk) begin
        if (pop)
            job_reg <= head_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
            sel_reg   <= 1'b0;
        end else if (valid_reg && m_ready) begin
            if (sel_is_last)
                valid_reg <= 1'b0;
            else
                sel_reg <= 1'b1;
        end
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Testbench for delimiter_mask_field_splitter: directed lines, then random
// text under changing masks, with every record checked against a line model.
// Depends on dmfs_pkg and the design sources.

module testbench;

    // one expected or observed output transaction, laid out as the ports
    typedef struct packed {
        dmfs_pkg::record_kind_t kind;
        logic [2:0]             index;
        logic [7:0]             start;
        logic [7:0]             length;
        dmfs_pkg::line_status_t status;
        logic                   last;
    } split_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [63:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_buffer_last;
    logic        m_valid;
    logic        m_ready;
    logic        m_record_kind;
    logic [2:0]  m_field_index;
    logic [7:0]  m_field_start;
    logic [7:0]  m_field_length;
    logic [1:0]  m_line_status;
    logic        m_last;

    // line model: register copies and per-line state
    logic [3:0]             split_count;
    logic [63:0]            split_chars;
    logic [7:0]             line_pos;
    logic [3:0]             mask_pos;
    logic [2:0]             field_num;
    logic [7:0]             field_beg;
    logic [7:0]             field_len;
    dmfs_pkg::line_status_t line_res;
    logic                   skip_line;

    split_rec_t field_records_due[$];

    // what the stimulus side last wrote, used to aim at the mask
    logic [3:0]  drive_count;
    logic [63:0] drive_chars;

    int  mismatches;
    int  bytes_sent;
    int  recs_checked;
    int  settings_used;
    int  lines_by_status [4];
    bit  calm;

    delimiter_mask_field_splitter dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_buffer_last  (s_buffer_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_record_kind  (m_record_kind),
        .m_field_index  (m_field_index),
        .m_field_start  (m_field_start),
        .m_field_length (m_field_length),
        .m_line_status  (m_line_status),
        .m_last         (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line model
    // ------------------------------------------------------------------

    function automatic logic [7:0] bump(input logic [7:0] v);
        return (v == 8'hff) ? v : v + 8'd1;
    endfunction

    function automatic split_rec_t open_field();
        return '{kind: dmfs_pkg::KIND_FIELD, index: field_num, start: field_beg,
                 length: field_len, status: dmfs_pkg::ST_OK, last: 1'b0};
    endfunction

    function automatic string rec_text(input split_rec_t r);
        return $sformatf("kind %0d idx %0d start %0d len %0d status %0d last %0d",
                         r.kind, r.index, r.start, r.length, r.status, r.last);
    endfunction

    // every line starts from here, also after reset
    task automatic restart_line();
        line_pos  = 8'd0;
        mask_pos  = 4'd0;
        field_num = 3'd0;
        field_beg = 8'd0;
        field_len = 8'd0;
        line_res  = dmfs_pkg::ST_EMPTY;
        skip_line = 1'b0;
    endtask

    // Advance the model by one accepted byte and queue the records it causes.
    task automatic split_byte(input logic [7:0] b, input logic at_end);
        split_rec_t recs [2];
        int         n;
        int         cnt;
        logic       open_out;
        n        = 0;
        open_out = 1'b0;
        // count register clamps to 1..8
        cnt = (split_count == 4'd0) ? 1 : ((split_count > 4'd8) ? 8 : int'(split_count));
        if (!skip_line) begin
            if (b == dmfs_pkg::CHAR_HASH) begin
                line_res  = dmfs_pkg::ST_COMMENT;
                skip_line = 1'b1;
            end else if (b == dmfs_pkg::CHAR_LF) begin
                open_out = 1'b1;
            end else if (b == dmfs_pkg::CHAR_CR) begin
                // CR holds a position, adds no length
                open_out = at_end;
            end else if (b == split_chars[mask_pos[2:0] * 8 +: 8]) begin
                line_res = dmfs_pkg::ST_INCOMPLETE;
                recs[n]  = open_field();
                n++;
                field_len = 8'd0;
                mask_pos  = mask_pos + 4'd1;
                if (mask_pos >= cnt) begin
                    // mask used up
                    line_res  = dmfs_pkg::ST_OK;
                    skip_line = 1'b1;
                end else if (field_num + 1 >= dmfs_pkg::MAX_FIELDS) begin
                    // field limit reached, status stays incomplete
                    skip_line = 1'b1;
                end else begin
                    field_num = field_num + 3'd1;
                    field_beg = bump(line_pos);
                end
            end else begin
                field_len = bump(field_len);
                open_out  = at_end;
            end
        end
        if (open_out) begin
            recs[n] = open_field();
            n++;
        end
        line_pos = bump(line_pos);
        if (at_end || b == dmfs_pkg::CHAR_LF) begin
            recs[n] = '{kind: dmfs_pkg::KIND_STATUS, index: 3'd0, start: 8'd0,
                        length: 8'd0, status: line_res, last: 1'b0};
            n++;
            restart_line();
        end
        for (int i = 0; i < n; i++) begin
            recs[i].last = (i == n - 1);
            field_records_due.push_back(recs[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Model update and record check, all at the rising edge so that the
    // handshakes are seen with their pre-edge values.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        split_rec_t want;
        split_rec_t got;
        if (!aresetn) begin
            split_count = 4'd1;
            split_chars = 64'd0;
            restart_line();
        end else begin
            if (cfg_we) begin
                if (cfg_index == dmfs_pkg::REG_DELIM_COUNT)
                    split_count = cfg_wdata[3:0];
                else
                    split_chars = cfg_wdata;
            end
            if (s_valid && s_ready)
                split_byte(s_data_byte, s_buffer_last);
            if (m_valid && m_ready) begin
                got = {m_record_kind, m_field_index, m_field_start, m_field_length,
                       m_line_status, m_last};
                recs_checked++;
                if (got.kind == dmfs_pkg::KIND_STATUS)
                    lines_by_status[got.status]++;
                if (field_records_due.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("ERROR %0t: record with nothing due", $time);
                        $display("  actual   %s", rec_text(got));
                    end
                    mismatches++;
                end else begin
                    want = field_records_due.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10) begin
                            $display("ERROR %0t: record mismatch", $time);
                            $display("  expected %s", rec_text(want));
                            $display("  actual   %s", rec_text(got));
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    // receiver: stalls about a quarter of the cycles unless calm
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 24);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One input transaction. Valid stays up across back-to-back bytes.
    task automatic send_byte(input logic [7:0] b, input logic at_end);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_byte   <= b;
        s_buffer_last <= at_end;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(input string txt, input logic end_on_last);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], end_on_last && (i == txt.len() - 1));
    endtask

    // hold off the sender until every record is out, then let the pipe empty
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (field_records_due.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_mask(input logic [3:0] count, input logic [63:0] chars);
        settle();
        write_reg(dmfs_pkg::REG_DELIM_COUNT, {60'd0, count});
        write_reg(dmfs_pkg::REG_DELIM_CHARS, chars);
        drive_count = count;
        drive_chars = chars;
        settings_used++;
    endtask

    // a byte that is neither special nor any mask character
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        logic       hit;
        do begin
            b   = 8'($urandom_range(255));
            hit = (b == dmfs_pkg::CHAR_HASH) || (b == dmfs_pkg::CHAR_CR) ||
                  (b == dmfs_pkg::CHAR_LF);
            for (int k = 0; k < dmfs_pkg::MASK_BYTES; k++)
                if (b == drive_chars[k * 8 +: 8])
                    hit = 1'b1;
        end while (hit);
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset mask is count 1, char 0x00: a zero byte closes field 0
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b1);
    endtask

    // fields, CR inside a field, open field closed by LF
    task automatic test_field_records();
        set_mask(4'd3, 64'hffee_ddcc_bb3a_3b2c);
        send_text("a,\r;x\n", 1'b0);
    endtask

    // '#' drops the open field and skips the line
    task automatic test_comment();
        send_text("#,\n", 1'b0);
    endtask

    // buffer end on a plain byte, on a delimiter and on a CR
    task automatic test_buffer_end();
        send_text("q", 1'b1);
        send_text(",", 1'b1);
        send_text("\r", 1'b1);
    endtask

    // count 0 acts as 1: one delimiter uses up the mask, rest is skipped
    task automatic test_count_zero();
        set_mask(4'd0, 64'h0000_0000_3a3b_3b2c);
        send_text(",m\n", 1'b0);
    endtask

    // mask entries equal to CR or LF can never close a field
    task automatic test_special_mask_bytes();
        set_mask(4'd2, {48'd0, dmfs_pkg::CHAR_LF, dmfs_pkg::CHAR_CR});
        send_text("\r\n", 1'b0);
    endtask

    // six delimiters hit the field limit before an eight entry mask runs out
    task automatic test_too_many_fields();
        set_mask(4'd8, {8{8'h2c}});
        send_text(",,,,,,\n", 1'b0);
    endtask

    // lower the count mid-line below the mask position already reached
    task automatic test_count_lowered();
        set_mask(4'd4, 64'h0000_0000_2e3a_3b2c);
        send_text("a,;", 1'b0);
        set_mask(4'd1, drive_chars);
        send_text(":\n", 1'b0);
    endtask

    // positions and lengths saturate at 255
    task automatic test_saturation();
        set_mask(4'd2, 64'h0000_0000_0000_3b2c);
        for (int i = 0; i < 258; i++)
            send_byte(plain_byte(), 1'b0);
        send_byte(8'h2c, 1'b0);
        for (int i = 0; i < 3; i++)
            send_byte(plain_byte(), 1'b0);
        send_text(";\n", 1'b0);
    endtask

    // Random lines under eight mask settings. About a third of the bytes aim
    // at the next mask character so that lines run deep; the rest is other mask
    // characters, CR, '#', stray line feeds and raw bytes.
    task automatic test_random_lines();
        int          phase_end;
        int          cnt;
        int          aim;
        int          len;
        int          r;
        logic [3:0]  count;
        logic [63:0] chars;
        logic [7:0]  b;
        logic        end_by_flag;
        logic        noisy;
        logic [7:0]  pool [8];
        pool = '{8'h2c, 8'h3b, 8'h3a, 8'h3d, 8'h20, 8'h09, 8'h7c, 8'h2f};
        for (int phase = 0; phase < 8; phase++) begin
            // extremes first, then anything the 4-bit register holds
            case (phase)
                0: count = 4'd1;
                1: count = 4'd8;
                2: count = 4'd15;
                default: count = 4'($urandom_range(15));
            endcase
            for (int k = 0; k < dmfs_pkg::MASK_BYTES; k++) begin
                r = $urandom_range(99);
                if (r < 70)
                    chars[k * 8 +: 8] = pool[3'($urandom_range(7))];
                else if (r < 80)
                    chars[k * 8 +: 8] = 8'($urandom_range(255));
                else if (r < 84)
                    chars[k * 8 +: 8] = dmfs_pkg::CHAR_HASH;
                else if (r < 87)
                    chars[k * 8 +: 8] = dmfs_pkg::CHAR_CR;
                else if (r < 90)
                    chars[k * 8 +: 8] = dmfs_pkg::CHAR_LF;
                else
                    chars[k * 8 +: 8] = (r < 95) ? 8'h00 : 8'hff;
            end
            if (phase == 5)
                chars = {64{1'b1}};
            set_mask(count, chars);
            // one phase runs with neither side idling
            calm = (phase == 3);
            cnt  = (drive_count == 4'd0) ? 1 :
                   ((drive_count > 4'd8) ? 8 : int'(drive_count));
            phase_end = bytes_sent + 68;
            while (bytes_sent < phase_end) begin
                aim         = 0;
                len         = ($urandom_range(9) == 0) ? $urandom_range(15, 40)
                                                       : $urandom_range(0, 10);
                end_by_flag = ($urandom_range(99) < 20);
                noisy       = ($urandom_range(99) < 10);
                for (int j = 0; j < len; j++) begin
                    r = $urandom_range(99);
                    if (noisy) begin
                        b = 8'($urandom_range(255));
                    end else if (r < 35) begin
                        b   = drive_chars[aim * 8 +: 8];
                        aim = (aim + 1) % cnt;
                    end else if (r < 45) begin
                        b = drive_chars[$urandom_range(7) * 8 +: 8];
                    end else if (r < 50) begin
                        b = dmfs_pkg::CHAR_CR;
                    end else if (r < 52) begin
                        b = dmfs_pkg::CHAR_HASH;
                    end else if (r < 54) begin
                        b = dmfs_pkg::CHAR_LF;
                    end else if (r < 64) begin
                        b = 8'($urandom_range(255));
                    end else begin
                        b = plain_byte();
                    end
                    send_byte(b, end_by_flag && (j == len - 1));
                end
                if (!end_by_flag || len == 0)
                    send_byte(dmfs_pkg::CHAR_LF, ($urandom_range(99) < 5));
            end
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = dmfs_pkg::REG_DELIM_COUNT;
        cfg_wdata     = 64'd0;
        s_valid       = 1'b0;
        s_data_byte   = 8'd0;
        s_buffer_last = 1'b0;
        m_ready       = 1'b0;
        calm          = 1'b0;
        drive_count   = 4'd1;
        drive_chars   = 64'd0;
        mismatches    = 0;
        bytes_sent    = 0;
        recs_checked  = 0;
        settings_used = 0;
        lines_by_status = '{0, 0, 0, 0};
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_field_records();
        test_comment();
        test_buffer_end();
        test_count_zero();
        test_special_mask_bytes();
        test_too_many_fields();
        test_count_lowered();
        test_saturation();
        test_random_lines();

        settle();
        repeat (20) @(posedge aclk);
        if (field_records_due.size() != 0) begin
            $display("ERROR: %0d records never arrived", field_records_due.size());
            mismatches += field_records_due.size();
        end
        $display("Run: %0d bytes under %0d mask settings, %0d records checked",
                 bytes_sent, settings_used, recs_checked);
        $display("Lines closed: ok %0d, incomplete %0d, comment %0d, empty %0d",
                 lines_by_status[dmfs_pkg::ST_OK],
                 lines_by_status[dmfs_pkg::ST_INCOMPLETE],
                 lines_by_status[dmfs_pkg::ST_COMMENT],
                 lines_by_status[dmfs_pkg::ST_EMPTY]);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("ERROR: timeout");
        $display("Some tests failed");
        $finish;
    end

endmodule
